[hw/rtl/epcf_pkg.sv]
// Shared types, constants and helpers for the event pixel comb filter.
// Used by epcf_mac, epcf_ctrl and the top level event_pixel_comb_filter.
package epcf_pkg;

   // Default geometry and comb delays.
   localparam int EPCF_MAX_COLS          = 32;
   localparam int EPCF_MAX_ROWS          = 32;
   localparam int EPCF_LONG_DELAY_TICKS  = 100;
   localparam int EPCF_SHORT_DELAY_TICKS = 10;

   localparam int DATA_W = 32;
   localparam int GAIN_W = 18;
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + GAIN_W;
   localparam int ACC_W  = 53;
   localparam int SAT_W  = 40;

   // A gain of one in Q.16, used for the unscaled terms.
   localparam logic signed [GAIN_W-1:0] GAIN_ONE = 18'sd65536;
   localparam logic signed [SAT_W-1:0]  SAT_MAX  = 40'sd2147483647;
   localparam logic signed [SAT_W-1:0]  SAT_MIN  = -40'sd2147483648;

   // Request function codes.
   localparam logic [1:0] FUNC_EVENT = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Register indexes on the control port.
   localparam logic [2:0] CSR_CONTRAST_ON     = 3'd0;
   localparam logic [2:0] CSR_CONTRAST_OFF    = 3'd1;
   localparam logic [2:0] CSR_FEEDBACK_GAIN   = 3'd2;
   localparam logic [2:0] CSR_COMPENSATE_GAIN = 3'd3;
   localparam logic [2:0] CSR_ROWS_IN_USE     = 3'd4;
   localparam logic [2:0] CSR_COLS_IN_USE     = 3'd5;

   typedef struct packed {
      logic [16:0]        contrast_on;
      logic signed [16:0] contrast_off;
      logic [15:0]        feedback_gain;
      logic [15:0]        compensate_gain;
      logic [5:0]         rows_in_use;
      logic [5:0]         cols_in_use;
   } cfg_type;

   // One multiply-accumulate operation: acc (+)= (a - b) * gain.
   typedef struct packed {
      logic                     valid;
      logic                     clear;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [GAIN_W-1:0] gain;
   } mac_cmd_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/event_pixel_comb_filter.sv]
// Top level of the event pixel comb filter: control registers, stream ports
// and result register. Depends on epcf_pkg and instantiates epcf_ctrl.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_tvalid/tready     tuser func, tdata pixel and polarity
//   rsp_     out        rsp_tvalid/tready     tdata filtered and integrated value
//   csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
// A dropped event or an unknown function returns straight to idle, and a read
// may wait for the result register. One shared multiply-accumulate unit
// handles four products per pixel in a tick. After reset the integrator store
// is cleared before the first request is taken. A stalled result does not
// block events or ticks; only the next read waits for it.
module event_pixel_comb_filter
   import epcf_pkg::*;
#(
   parameter int MAX_COLS          = EPCF_MAX_COLS,
   parameter int MAX_ROWS          = EPCF_MAX_ROWS,
   parameter int LONG_DELAY_TICKS  = EPCF_LONG_DELAY_TICKS,
   parameter int SHORT_DELAY_TICKS = EPCF_SHORT_DELAY_TICKS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pixel_x[4:0], pixel_y[9:5], polarity[10], zero fill
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // filtered_value[31:0], integrated_value[63:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff;
   logic               res_valid, res_ready;
   logic signed [31:0] res_filtered, res_integrated;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CONTRAST_ON:     cfg_in.contrast_on     = csr_data;
            CSR_CONTRAST_OFF:    cfg_in.contrast_off    = $signed(csr_data);
            CSR_FEEDBACK_GAIN:   cfg_in.feedback_gain   = csr_data[15:0];
            CSR_COMPENSATE_GAIN: cfg_in.compensate_gain = csr_data[15:0];
            CSR_ROWS_IN_USE:     cfg_in.rows_in_use     = csr_data[5:0];
            CSR_COLS_IN_USE:     cfg_in.cols_in_use     = csr_data[5:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   epcf_ctrl #(
      .MAX_COLS          (MAX_COLS),
      .MAX_ROWS          (MAX_ROWS),
      .LONG_DELAY_TICKS  (LONG_DELAY_TICKS),
      .SHORT_DELAY_TICKS (SHORT_DELAY_TICKS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_func       (req_tuser),
      .req_px         (req_tdata[4:0]),
      .req_py         (req_tdata[9:5]),
      .req_pol        (req_tdata[10]),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res_filtered   (res_filtered),
      .res_integrated (res_integrated)
   );

   // The result register takes a new result whenever it is empty or drains.
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.contrast_on     <= 17'd6554;
         cfg_ff.contrast_off    <= -17'sd6554;
         cfg_ff.feedback_gain   <= 16'd64881;
         cfg_ff.compensate_gain <= 16'd65470;
         cfg_ff.rows_in_use     <= 6'd32;
         cfg_ff.cols_in_use     <= 6'd32;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= {res_integrated, res_filtered};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/epcf_mac.sv]
// Shared multiply-accumulate unit of the comb filter with Q16.16 rounding.
// Depends on epcf_pkg for the command struct and the saturation helper.
module epcf_mac
   import epcf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_cmd_type              cmd,
   output logic signed [DATA_W-1:0] result
);

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvalid_ff;
   logic                     pclear_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W:0]    rnd;
   logic signed [ACC_W-16:0] quo;

   assign diff    = DIFF_W'(cmd.a) - DIFF_W'(cmd.b);
   assign prod_in = PROD_W'(diff) * PROD_W'(cmd.gain);
   assign acc_in  = (pclear_ff ? '0 : acc_ff) + ACC_W'(prod_ff);

   // Add one half and floor to Q16.16, then clamp to 32 bits.
   assign rnd    = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(32768);
   assign quo    = rnd[ACC_W:16];
   assign result = sat32(SAT_W'(quo));

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         pclear_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.valid;
         pclear_ff <= cmd.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         prod_ff <= prod_in;
      end
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
   end

endmodule

[hw/rtl/epcf_ctrl.sv]
// Sequencer and pixel stores of the comb filter: integrator, input and output
// frame histories. Depends on epcf_pkg and instantiates epcf_mac.
module epcf_ctrl
   import epcf_pkg::*;
#(
   parameter int MAX_COLS          = EPCF_MAX_COLS,
   parameter int MAX_ROWS          = EPCF_MAX_ROWS,
   parameter int LONG_DELAY_TICKS  = EPCF_LONG_DELAY_TICKS,
   parameter int SHORT_DELAY_TICKS = EPCF_SHORT_DELAY_TICKS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_func,
   input  logic [4:0]               req_px,
   input  logic [4:0]               req_py,
   input  logic                     req_pol,
   output logic                     res_valid,
   input  logic                     res_ready,
   output logic signed [DATA_W-1:0] res_filtered,
   output logic signed [DATA_W-1:0] res_integrated
);

   localparam int RING   = LONG_DELAY_TICKS + SHORT_DELAY_TICKS + 1;
   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int PW     = RW + CW;
   localparam int SW     = $clog2(RING);
   localparam int IDEPTH = 1 << PW;
   localparam int HDEPTH = RING << PW;
   localparam int HAW    = SW + PW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EV_RD, S_EV_WR, S_RD_ADDR, S_RD_OUT,
      S_TK_START, S_TK_A, S_TK_B, S_TK_C, S_TK_D, S_TK_E, S_TK_F, S_TK_END
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0]             row_ff, row_in;
   logic [CW-1:0]             col_ff, col_in;
   logic [PW-1:0]             wr_p_ff, wr_p_in;
   logic                      pend_ff, pend_in;
   logic [PW-1:0]             clr_ff, clr_in;
   logic [SW-1:0]             ws_ff, ws_in;
   logic [SW-1:0]             fill_ff, fill_in;
   logic [SW-1:0]             s1_ff, s1_in, s2_ff, s2_in, s12_ff, s12_in;
   logic signed [GAIN_W-1:0]  step_ff, step_in;
   logic                      in_range_ff, in_range_in;

   logic [DATA_W-1:0]         integ_mem [0:IDEPTH-1];
   logic [DATA_W-1:0]         in_hist_mem [0:HDEPTH-1];
   logic [DATA_W-1:0]         out_hist_mem [0:HDEPTH-1];
   logic signed [DATA_W-1:0]  integ_rd_ff, ih_rd0_ff, ih_rd1_ff, oh_rd0_ff, oh_rd1_ff;

   logic                      integ_re, integ_we;
   logic [PW-1:0]             integ_ra, integ_wa;
   logic [DATA_W-1:0]         integ_wd;
   logic                      ih_re0, ih_re1, oh_re0, oh_re1, hist_we;
   logic [HAW-1:0]            ih_ra0, ih_ra1, oh_ra0, oh_ra1, hist_wa;

   mac_cmd_type               mac_cmd;
   logic signed [DATA_W-1:0]  mac_y;

   logic [PW-1:0]             p_cur;
   logic [SW-1:0]             prev_slot;
   logic [31:0]               px_ext, py_ext;
   logic                      frame_ok, ev_ok;
   logic                      v1, v2, v12;
   logic signed [DATA_W:0]    ev_sum;

   epcf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mac_cmd),
      .result (mac_y)
   );

   assign p_cur     = {row_ff, col_ff};
   assign prev_slot = (ws_ff == '0) ? SW'(RING - 1) : ws_ff - SW'(1);
   assign px_ext    = 32'(req_px);
   assign py_ext    = 32'(req_py);
   assign frame_ok  = (px_ext < 32'(MAX_COLS)) && (py_ext < 32'(MAX_ROWS));
   assign ev_ok     = frame_ok && (req_px != '0) && (req_py != '0) &&
                      ({1'b0, req_px} < cfg.cols_in_use) &&
                      ({1'b0, req_py} < cfg.rows_in_use);

   // The histories fill one whole slot per tick, so a slot d ticks back holds
   // written data once at least d ticks have run; before that it reads as zero.
   assign v1  = fill_ff >= SW'(LONG_DELAY_TICKS);
   assign v2  = fill_ff >= SW'(SHORT_DELAY_TICKS);
   assign v12 = fill_ff >= SW'(LONG_DELAY_TICKS + SHORT_DELAY_TICKS);

   assign ev_sum = (DATA_W+1)'(integ_rd_ff) + (DATA_W+1)'(step_ff);
   assign hist_wa = {ws_ff, wr_p_ff};

   assign res_filtered   = (in_range_ff && fill_ff != '0) ? oh_rd0_ff : '0;
   assign res_integrated = in_range_ff ? integ_rd_ff : '0;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      wr_p_in     = wr_p_ff;
      pend_in     = pend_ff;
      clr_in      = clr_ff;
      ws_in       = ws_ff;
      fill_in     = fill_ff;
      s1_in       = s1_ff;
      s2_in       = s2_ff;
      s12_in      = s12_ff;
      step_in     = step_ff;
      in_range_in = in_range_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      integ_re    = 1'b0;
      integ_we    = 1'b0;
      integ_ra    = p_cur;
      integ_wa    = p_cur;
      integ_wd    = '0;
      ih_re0      = 1'b0;
      ih_re1      = 1'b0;
      oh_re0      = 1'b0;
      oh_re1      = 1'b0;
      ih_ra0      = {s1_ff, p_cur};
      ih_ra1      = {s2_ff, p_cur};
      oh_ra0      = {s2_ff, p_cur};
      oh_ra1      = {s1_ff, p_cur};
      hist_we     = 1'b0;
      mac_cmd     = '0;
      case (state_ff)
         S_CLEAR: begin
            integ_we = 1'b1;
            integ_wa = clr_ff;
            clr_in   = clr_ff + PW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            row_in      = py_ext[RW-1:0];
            col_in      = px_ext[CW-1:0];
            in_range_in = frame_ok;
            step_in     = req_pol ? $signed({1'b0, cfg.contrast_on})
                                  : GAIN_W'(cfg.contrast_off);
            if (req_valid) begin
               case (req_func)
                  FUNC_EVENT: state_in = ev_ok ? S_EV_RD : S_IDLE;
                  FUNC_TICK:  state_in = S_TK_START;
                  FUNC_READ:  state_in = S_RD_ADDR;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_EV_RD: begin
            integ_re = 1'b1;
            state_in = S_EV_WR;
         end
         S_EV_WR: begin
            integ_we = 1'b1;
            integ_wd = sat32(SAT_W'(ev_sum));
            state_in = S_IDLE;
         end
         S_RD_ADDR: begin
            integ_re = 1'b1;
            oh_re0   = 1'b1;
            oh_ra0   = {prev_slot, p_cur};
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         S_TK_START: begin
            s1_in  = (ws_ff >= SW'(LONG_DELAY_TICKS)) ?
                     ws_ff - SW'(LONG_DELAY_TICKS) :
                     ws_ff + SW'(RING - LONG_DELAY_TICKS);
            s2_in  = (ws_ff >= SW'(SHORT_DELAY_TICKS)) ?
                     ws_ff - SW'(SHORT_DELAY_TICKS) :
                     ws_ff + SW'(RING - SHORT_DELAY_TICKS);
            s12_in = (ws_ff >= SW'(RING - 1)) ?
                     ws_ff - SW'(RING - 1) : ws_ff + SW'(1);
            row_in   = '0;
            col_in   = '0;
            pend_in  = 1'b0;
            state_in = S_TK_A;
         end
         S_TK_A: begin
            // Fetch x, x[d1] and y[d2] of this pixel; store the previous one.
            integ_re = 1'b1;
            ih_re0   = 1'b1;
            oh_re0   = 1'b1;
            hist_we  = pend_ff;
            state_in = S_TK_B;
         end
         S_TK_B: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.clear = 1'b1;
            mac_cmd.a     = integ_rd_ff;
            mac_cmd.b     = v1 ? ih_rd0_ff : '0;
            mac_cmd.gain  = GAIN_ONE;
            ih_re0        = 1'b1;
            ih_ra0        = {s12_ff, p_cur};
            ih_re1        = 1'b1;
            oh_re1        = 1'b1;
            state_in      = S_TK_C;
         end
         S_TK_C: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.a     = v2 ? oh_rd0_ff : '0;
            mac_cmd.gain  = GAIN_ONE;
            oh_re0        = 1'b1;
            oh_ra0        = {s12_ff, p_cur};
            state_in      = S_TK_D;
         end
         S_TK_D: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.a     = v12 ? ih_rd0_ff : '0;
            mac_cmd.b     = v2 ? ih_rd1_ff : '0;
            mac_cmd.gain  = $signed({2'b00, cfg.compensate_gain});
            state_in      = S_TK_E;
         end
         S_TK_E: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.a     = v1 ? oh_rd1_ff : '0;
            mac_cmd.b     = v12 ? oh_rd0_ff : '0;
            mac_cmd.gain  = $signed({2'b00, cfg.feedback_gain});
            state_in      = S_TK_F;
         end
         S_TK_F: begin
            wr_p_in  = p_cur;
            pend_in  = 1'b1;
            state_in = S_TK_A;
            if (col_ff == CW'(MAX_COLS - 1)) begin
               col_in = '0;
               if (row_ff == RW'(MAX_ROWS - 1)) begin
                  state_in = S_TK_END;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         S_TK_END: begin
            hist_we  = 1'b1;
            pend_in  = 1'b0;
            ws_in    = (ws_ff == SW'(RING - 1)) ? '0 : ws_ff + SW'(1);
            fill_in  = (fill_ff == SW'(RING - 1)) ? fill_ff : fill_ff + SW'(1);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ws_ff    <= '0;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ws_ff    <= ws_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      wr_p_ff     <= wr_p_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s12_ff      <= s12_in;
      step_ff     <= step_in;
      in_range_ff <= in_range_in;
   end

   always_ff @(posedge clock) begin
      if (integ_we) begin
         integ_mem[integ_wa] <= integ_wd;
      end
      if (integ_re) begin
         integ_rd_ff <= integ_mem[integ_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         in_hist_mem[hist_wa] <= integ_rd_ff;
      end
      if (ih_re0) begin
         ih_rd0_ff <= in_hist_mem[ih_ra0];
      end
      if (ih_re1) begin
         ih_rd1_ff <= in_hist_mem[ih_ra1];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         out_hist_mem[hist_wa] <= mac_y;
      end
      if (oh_re0) begin
         oh_rd0_ff <= out_hist_mem[oh_ra0];
      end
      if (oh_re1) begin
         oh_rd1_ff <= out_hist_mem[oh_ra1];
      end
   end

endmodule
